### rtl/bmp24_pkg.sv
// Shared types, codes and helper functions of the 24-bit BMP stream decoder.
package bmp24_pkg;

  // Most result items caused by one input byte
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PIXEL     = 3'd0,
    KIND_HEADER    = 3'd1,
    KIND_NOT_BMP   = 3'd2,
    KIND_NOT_24    = 3'd3,
    KIND_TRUNCATED = 3'd4,
    KIND_TOO_LARGE = 3'd5
  } kind_t;

  // Stream phases
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXELS = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Output component settings
  localparam logic [2:0] COMP_GRAY = 3'd1;
  localparam logic [2:0] COMP_RGB  = 3'd3;
  localparam logic [2:0] COMP_RGBA = 3'd4;
  localparam logic [2:0] COMP_RESET = COMP_RGB;

  // Header byte positions
  localparam logic [5:0] POS_MAGIC0      = 6'd0;
  localparam logic [5:0] POS_MAGIC1      = 6'd1;
  localparam logic [5:0] POS_MAGIC_CHECK = 6'd13;
  localparam logic [5:0] POS_WIDTH       = 6'd18;
  localparam logic [5:0] POS_HEIGHT      = 6'd22;
  localparam logic [5:0] POS_BPP         = 6'd28;
  localparam logic [5:0] POS_HDR_LAST    = 6'd53;

  localparam logic [7:0]  CHAR_B     = 8'h42;
  localparam logic [7:0]  CHAR_M     = 8'h4D;
  localparam logic [15:0] BPP_24     = 16'd24;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;

  // Reciprocal of three for sums up to 765: floor(x/3) = (x*683) >> 11
  localparam logic [9:0] THIRD_RECIP = 10'd683;
  localparam int unsigned THIRD_SHIFT = 11;

  typedef logic [CNT_W-1:0] count_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel;
    logic [12:0] width;
    logic [12:0] height;
    logic        last_of_pixel;
    logic        end_of_image;
  } res_t;

  typedef res_t [MAX_RES-1:0] burst_t;

  // Results of one byte handed to the output buffer
  typedef struct packed {
    logic   valid;
    count_t count;
    burst_t res;
  } load_t;

  function automatic res_t mk_pixel(logic [7:0] value, logic lp, logic eoi);
    res_t r;
    r = '0;
    r.kind          = KIND_PIXEL;
    r.pixel         = value;
    r.last_of_pixel = lp;
    r.end_of_image  = eoi;
    return r;
  endfunction

  function automatic res_t mk_status(kind_t kind, logic [12:0] w, logic [12:0] h,
                                     logic eoi);
    res_t r;
    r = '0;
    r.kind         = kind;
    r.width        = w;
    r.height       = h;
    r.end_of_image = eoi;
    return r;
  endfunction

  // Gray level: sum of the three components divided by three
  function automatic logic [7:0] gray_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(b) + 10'(g) + 10'(r);
    prod = 20'(sum) * 20'(THIRD_RECIP);
    return prod[THIRD_SHIFT+7:THIRD_SHIFT];
  endfunction

endpackage

### rtl/bmp24_obuf.sv
// Result buffer: holds the results of one byte and drains them one per cycle while out_ready is high.
module bmp24_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  bmp24_pkg::load_t  load,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output bmp24_pkg::res_t   out_res
);
  import bmp24_pkg::*;

  burst_t buf_r, buf_nxt;
  count_t cnt_r, cnt_nxt;
  logic   pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = buf_r[0];
  // Free once the last held result leaves this cycle
  assign space     = (cnt_r == '0) || ((cnt_r == count_t'(1)) && out_ready);

  // Load a new burst or shift the held one down
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load.valid) begin
      buf_nxt = load.res;
      cnt_nxt = load.count;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

### rtl/bmp24_pixel_stream_decoder.sv
// Top level of the 24-bit BMP stream decoder: header parser and pixel converter.
//
// Feed the BMP file one byte per request on in_; in_tlast marks end of file and
// carries no byte. The block parses the 54 header bytes, reports the image size
// (or an error) as one result, then converts each blue-green-red triple into
// 1, 3 or 4 result bytes as cfg_data selects, skipping row padding. Bytes that
// cause no result pass at one per cycle; a byte that completes a pixel puts up to
// four results in the output buffer, which drains one per cycle while out_tready
// is high, and the next result-bearing byte waits for it. Output bandwidth of one
// result per cycle limits the byte rate for RGBA. The input byte is registered,
// and its results are registered in the output buffer before they appear. Write the
// component register only while the block is idle; cfg_ready is always high.
module bmp24_pixel_stream_decoder #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] pixel_byte, [20:8] image_width,
                                  // [33:21] image_height, [39:34] zero
  output logic [3:0]  out_tuser,  // [2:0] kind, [3] last_of_pixel
  output logic        out_tlast,  // end_of_image
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // output_components
);
  import bmp24_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);

  // Input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eof_r;

  // Stream state
  phase_t           phase_r, phase_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic             magic_r, magic_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [15:0]      bpp_r, bpp_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [1:0]       bip_r, bip_nxt;
  logic [7:0]       blue_r, blue_nxt;
  logic [7:0]       green_r, green_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [2:0]       comps_r;

  // Results of the byte in the input register
  burst_t res;
  count_t nres;
  logic   space;
  logic   fire;
  load_t  load;
  res_t   out_res;

  assign cfg_ready = 1'b1;

  // Take the byte on when the register is empty or its request is done
  assign fire      = in_v_r && ((nres == '0) || space);
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
  end

  // Component register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comps_r <= COMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      comps_r <= cfg_data;
    end
  end

  // Decode one byte against the stream state
  always_comb begin
    logic [5:0]       lane;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             last;
    logic [7:0]       b;

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    magic_nxt  = magic_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bip_nxt    = bip_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    pad_nxt    = pad_r;
    res        = '0;
    nres       = '0;
    lane       = '0;
    col_inc    = col_r + DIM_W'(1);
    row_inc    = row_r + DIM_W'(1);
    last       = 1'b0;
    b          = in_byte_r;

    if (in_eof_r) begin
      // End of file: report truncation if an image was under way, then clear
      if ((phase_r == PH_PIXELS) || (phase_r == PH_PAD) ||
          ((phase_r == PH_HEADER) && (pos_r != '0))) begin
        res[0] = mk_status(KIND_TRUNCATED, '0, '0, 1'b0);
        nres   = count_t'(1);
      end
      phase_nxt  = PH_HEADER;
      pos_nxt    = '0;
      magic_nxt  = 1'b0;
      width_nxt  = '0;
      height_nxt = '0;
      bpp_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      bip_nxt    = '0;
      blue_nxt   = '0;
      green_nxt  = '0;
      pad_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          pos_nxt = pos_r + 6'd1;
          case (pos_r) inside
            POS_MAGIC0: magic_nxt = (b == CHAR_B);
            POS_MAGIC1: magic_nxt = magic_r && (b == CHAR_M);
            [POS_WIDTH:POS_WIDTH+6'd3]: begin
              lane = pos_r - POS_WIDTH;
              width_nxt[8*lane[1:0] +: 8] = b;
            end
            [POS_HEIGHT:POS_HEIGHT+6'd3]: begin
              lane = pos_r - POS_HEIGHT;
              height_nxt[8*lane[1:0] +: 8] = b;
            end
            [POS_BPP:POS_BPP+6'd1]: begin
              lane = pos_r - POS_BPP;
              bpp_nxt[8*lane[0] +: 8] = b;
            end
            default: ;
          endcase
          // Magic fails after the file header; size and depth checks on the last byte
          if ((pos_r == POS_MAGIC_CHECK) && !magic_r) begin
            phase_nxt = PH_DONE;
            res[0]    = mk_status(KIND_NOT_BMP, '0, '0, 1'b0);
            nres      = count_t'(1);
          end else if (pos_r == POS_HDR_LAST) begin
            phase_nxt = PH_DONE;
            nres      = count_t'(1);
            if (bpp_r != BPP_24) begin
              res[0] = mk_status(KIND_NOT_24, '0, '0, 1'b0);
            end else if ((width_r == '0) || width_r[31] ||
                         (height_r == '0) || height_r[31]) begin
              res[0] = mk_status(KIND_HEADER, '0, '0, 1'b1);
            end else if ((width_r > 32'(MAX_DIMENSION)) ||
                         (height_r > 32'(MAX_DIMENSION))) begin
              res[0] = mk_status(KIND_TOO_LARGE, '0, '0, 1'b0);
            end else begin
              phase_nxt = PH_PIXELS;
              res[0]    = mk_status(KIND_HEADER, width_r[12:0], height_r[12:0], 1'b0);
            end
          end
        end
        PH_PIXELS: begin
          if (bip_r == 2'd0) begin
            blue_nxt = b;
            bip_nxt  = 2'd1;
          end else if (bip_r == 2'd1) begin
            green_nxt = b;
            bip_nxt   = 2'd2;
          end else begin
            // Red completes the pixel: advance column and row
            bip_nxt = 2'd0;
            col_nxt = col_inc;
            if (32'(col_inc) >= width_r) begin
              col_nxt = '0;
              row_nxt = row_inc;
              if (32'(row_inc) >= height_r) begin
                last      = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                pad_nxt = width_r[1:0];
                if (width_r[1:0] != 2'd0) begin
                  phase_nxt = PH_PAD;
                end
              end
            end
            case (comps_r)
              COMP_GRAY: begin
                res[0] = mk_pixel(gray_of(blue_r, green_r, b), 1'b1, last);
                nres   = count_t'(1);
              end
              COMP_RGB: begin
                res[0] = mk_pixel(b, 1'b0, 1'b0);
                res[1] = mk_pixel(green_r, 1'b0, 1'b0);
                res[2] = mk_pixel(blue_r, 1'b1, last);
                nres   = count_t'(3);
              end
              COMP_RGBA: begin
                res[0] = mk_pixel(b, 1'b0, 1'b0);
                res[1] = mk_pixel(green_r, 1'b0, 1'b0);
                res[2] = mk_pixel(blue_r, 1'b0, 1'b0);
                res[3] = mk_pixel(ALPHA_FULL, 1'b1, last);
                nres   = count_t'(4);
              end
              default: ;
            endcase
          end
        end
        PH_PAD: begin
          // Drop padding bytes up to the four-byte boundary
          if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end
          if ((pad_r == 2'd0) || (pad_r == 2'd1)) begin
            phase_nxt = PH_PIXELS;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  // Update the stream state when a byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      magic_r  <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      bip_r    <= '0;
      blue_r   <= '0;
      green_r  <= '0;
      pad_r    <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      magic_r  <= magic_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bip_r    <= bip_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
      pad_r    <= pad_nxt;
    end
  end

  // Hand results to the output buffer
  always_comb begin
    load.valid = fire && (nres != '0);
    load.count = nres;
    load.res   = res;
  end

  bmp24_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'd0, out_res.height, out_res.width, out_res.pixel};
  assign out_tuser = {out_res.last_of_pixel, out_res.kind};
  assign out_tlast = out_res.end_of_image;

endmodule
